// ===== rtl/core/lcmts_pkg.sv =====
// shared constants and types for the load cell median tare scaler
`default_nettype none

package lcmts_pkg;

  localparam int DEF_WINDOW      = 8;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int GAIN_BITS       = 32;
  localparam int TS_BITS         = 32;
  localparam int WEIGHT_BITS     = 32;

  localparam logic signed [GAIN_BITS-1:0] GAIN_RESET = 32'sd65536;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TARE   = 1'b1;

  // which middle positions the current candidate fills
  typedef struct packed {
    logic lo;
    logic hi;
  } rank_hit_t;

endpackage

`default_nettype wire

// ===== rtl/core/load_cell_median_tare_scaler.sv =====
// load cell median filter with tare offset and q16.16 scaling
// a sample makes one rank pass per filled entry, n being the fill count after it
// (1..WINDOW), through the shared compare row, then median, multiply and saturate steps;
// the next sample is taken once the previous one has left the saturate step, which stalls
// while the previous result still waits in the output register
// a tare request gives no result
// synchronous reset empties the window, clears tare offset and sets the scale to 1.0
`default_nettype none

module load_cell_median_tare_scaler
  import lcmts_pkg::*;
#(
  parameter int WINDOW      = DEF_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int IN_W       = ((SAMPLE_BITS + TS_BITS + 7) / 8) * 8,
  localparam int OUT_RAW_W  = SAMPLE_BITS + WEIGHT_BITS + 1 + TS_BITS,
  localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  var logic                  clk,
  input  var logic                  rst,
  input  var logic                  s_tvalid,
  output logic                      s_tready,
  input  var logic [IN_W-1:0]       s_tdata,   // sample, timestamp
  input  var logic                  s_tuser,   // mode
  output logic                      m_tvalid,
  input  var logic                  m_tready,
  output logic [OUT_W-1:0]          m_tdata,   // median_raw, weight_q16, saturated, timestamp_out
  input  var logic                  cfg_valid,
  output logic                      cfg_ready,
  input  var logic [GAIN_BITS-1:0]  cfg_data   // grams_per_count_q16
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int PROD_W = SAMPLE_BITS + 1 + GAIN_BITS;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RANK = 5'b00010,
    S_MED  = 5'b00100,
    S_MUL  = 5'b01000,
    S_SAT  = 5'b10000
  } state_t;

  state_t state;

  logic signed [SAMPLE_BITS-1:0] window [WINDOW];
  logic [SLOT_W-1:0]             write_slot;
  logic [CNT_W-1:0]              fill_count;
  logic signed [SAMPLE_BITS-1:0] tare_offset;
  logic signed [GAIN_BITS-1:0]   gain;

  logic [SLOT_W-1:0]             cand_idx;
  logic signed [SAMPLE_BITS-1:0] mid_lo;
  logic signed [SAMPLE_BITS-1:0] mid_hi;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [SAMPLE_BITS-1:0] median;
  logic signed [PROD_W-1:0]      prod;
  logic [TS_BITS-1:0]            ts_hold;

  logic                          accept;
  logic                          take;
  logic [CNT_W-1:0]              k_hi;
  logic [CNT_W-1:0]              k_lo;
  rank_hit_t                     hit;
  logic [CNT_W-1:0]              fill_inc;
  logic signed [SAMPLE_BITS:0]   pair_sum;
  logic signed [SAMPLE_BITS:0]   pair_adj;
  logic signed [SAMPLE_BITS-1:0] median_val;
  logic                          over;
  logic [WEIGHT_BITS-1:0]        weight;
  logic [SLOT_W-1:0]             last_idx;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign take      = m_tvalid && m_tready;

  // middle positions: equal for odd count, adjacent for even
  assign k_hi     = fill_count >> 1;
  assign k_lo     = fill_count[0] ? k_hi : k_hi - CNT_W'(1);
  assign last_idx = SLOT_W'(fill_count - CNT_W'(1));
  assign fill_inc = (fill_count < CNT_W'(WINDOW)) ? fill_count + CNT_W'(1) : fill_count;

  lcmts_rank_unit #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rank (
    .entries  (window),
    .cand_idx (cand_idx),
    .fill     (fill_count),
    .k_lo     (k_lo),
    .k_hi     (k_hi),
    .hit      (hit)
  );

  // mean of the middle pair, truncated toward zero
  assign pair_sum   = {mid_lo[SAMPLE_BITS-1], mid_lo} + {mid_hi[SAMPLE_BITS-1], mid_hi};
  assign pair_adj   = pair_sum + {{SAMPLE_BITS{1'b0}}, pair_sum[SAMPLE_BITS]};
  assign median_val = pair_adj[SAMPLE_BITS:1];

  // clip when the bits above the 32-bit range are not a pure sign extension
  assign over   = !((&prod[PROD_W-1:WEIGHT_BITS-1]) || !(|prod[PROD_W-1:WEIGHT_BITS-1]));
  assign weight = over ? {prod[PROD_W-1], {(WEIGHT_BITS-1){!prod[PROD_W-1]}}}
                       : prod[WEIGHT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_valid) begin
      gain <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser == MODE_SAMPLE) begin
      window[write_slot] <= s_tdata[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_slot  <= '0;
      fill_count  <= '0;
      tare_offset <= '0;
      m_tvalid    <= 1'b0;
      cand_idx    <= '0;
    end else begin
      if (state == S_SAT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (take) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tuser == MODE_TARE) begin
              tare_offset <= s_tdata[SAMPLE_BITS-1:0];
              write_slot  <= '0;
              fill_count  <= '0;
            end else begin
              write_slot <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0
                                                                 : write_slot + SLOT_W'(1);
              fill_count <= fill_inc;
              ts_hold    <= s_tdata[SAMPLE_BITS +: TS_BITS];
              cand_idx   <= '0;
              state      <= S_RANK;
            end
          end
        end
        S_RANK: begin
          if (hit.lo) begin
            mid_lo <= window[cand_idx];
          end
          if (hit.hi) begin
            mid_hi <= window[cand_idx];
          end
          if (cand_idx == last_idx) begin
            state <= S_MED;
          end else begin
            cand_idx <= cand_idx + SLOT_W'(1);
          end
        end
        S_MED: begin
          median <= median_val;
          diff   <= {median_val[SAMPLE_BITS-1], median_val}
                    - {tare_offset[SAMPLE_BITS-1], tare_offset};
          state  <= S_MUL;
        end
        S_MUL: begin
          prod  <= diff * gain;
          state <= S_SAT;
        end
        S_SAT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= OUT_W'({ts_hold, over, weight, median});
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lcmts_rank_unit.sv =====
// rank compare row: places one candidate entry among the filled window entries
`default_nettype none

module lcmts_rank_unit
  import lcmts_pkg::*;
#(
  parameter int WINDOW      = DEF_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int CNT_W      = $clog2(WINDOW + 1)
) (
  input  var logic signed [SAMPLE_BITS-1:0] entries [WINDOW],
  input  var logic [SLOT_W-1:0]             cand_idx,
  input  var logic [CNT_W-1:0]              fill,
  input  var logic [CNT_W-1:0]              k_lo,
  input  var logic [CNT_W-1:0]              k_hi,
  output rank_hit_t                         hit
);

  logic signed [SAMPLE_BITS-1:0] cand;
  logic [CNT_W-1:0]              less_cnt;
  logic [CNT_W-1:0]              leq_cnt;

  assign cand = entries[cand_idx];

  always_comb begin
    less_cnt = '0;
    leq_cnt  = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if (CNT_W'(j) < fill) begin
        less_cnt = less_cnt + CNT_W'(entries[j] < cand);
        leq_cnt  = leq_cnt + CNT_W'(entries[j] <= cand);
      end
    end
  end

  // candidate covers sorted positions less_cnt .. leq_cnt-1
  assign hit.lo = (less_cnt <= k_lo) && (k_lo < leq_cnt);
  assign hit.hi = (less_cnt <= k_hi) && (k_hi < leq_cnt);

endmodule

`default_nettype wire
